FILE: sv/preemptive_sjf_ready_queue_defines.svh
// Assertion macros shared by the checker of the ready queue.
`ifndef PREEMPTIVE_SJF_READY_QUEUE_DEFINES_SVH
`define PREEMPTIVE_SJF_READY_QUEUE_DEFINES_SVH

// The antecedent and the consequent hold in the same cycle.
`define PSJF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PSJF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/psjf_pkg.sv
// Types, constants and the key compare shared by the ready queue modules.
package psjf_pkg;

    localparam int BURST_W     = 16;
    localparam int ID_IN_W     = 8;
    localparam int ID_OUT_W    = 8;
    localparam int PRED_OUT_W  = 20;
    localparam int COUNT_OUT_W = 5;
    localparam int KEY_PRED_W  = 32;
    localparam int KEY_ID_W    = 16;

    typedef enum logic {
        MODE_READY = 1'b0,
        MODE_PICK  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREDICT,
        S_REPREDICT,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic predict;
        logic repredict;
        logic commit;
    } t_cmd;

    function automatic logic key_less(
        input logic [KEY_PRED_W-1:0] pa,
        input logic [KEY_ID_W-1:0]   ia,
        input logic [KEY_PRED_W-1:0] pb,
        input logic [KEY_ID_W-1:0]   ib
    );
        if (pa != pb) begin
            return pa < pb;
        end
        return ia < ib;
    endfunction

endpackage

FILE: sv/psjf_queue.sv
// Sorted shifting cell chain that holds the waiting threads by (prediction, id).
module psjf_queue #(
    parameter int DEPTH  = 16,
    parameter int ID_W   = 8,
    parameter int PRED_W = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_pop,
    input  logic [ID_W-1:0]              i_id,
    input  logic [PRED_W-1:0]            i_pred,
    output logic [ID_W-1:0]              o_head_id,
    output logic [PRED_W-1:0]            o_head_pred,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ID_W-1:0]   r_ids   [DEPTH];
    logic [PRED_W-1:0] r_preds [DEPTH];
    logic [ID_W-1:0]   n_ids   [DEPTH];
    logic [PRED_W-1:0] n_preds [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic [DEPTH-1:0]  w_keep;
    logic [DEPTH-1:0]  w_keep_up;
    logic [ID_W-1:0]   w_up_id   [DEPTH];
    logic [PRED_W-1:0] w_up_pred [DEPTH];
    logic [ID_W-1:0]   w_dn_id   [DEPTH];
    logic [PRED_W-1:0] w_dn_pred [DEPTH];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_keep[i] = (CNT_W'(i) < r_count) &&
                psjf_pkg::key_less(psjf_pkg::KEY_PRED_W'(r_preds[i]),
                                   psjf_pkg::KEY_ID_W'(r_ids[i]),
                                   psjf_pkg::KEY_PRED_W'(i_pred),
                                   psjf_pkg::KEY_ID_W'(i_id));
        end
    end

    always_comb begin
        w_keep_up[0] = 1'b1;
        w_up_id[0]   = i_id;
        w_up_pred[0] = i_pred;
        for (int i = 1; i < DEPTH; i++) begin
            w_keep_up[i] = w_keep[i-1];
            w_up_id[i]   = r_ids[i-1];
            w_up_pred[i] = r_preds[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++) begin
            w_dn_id[i]   = r_ids[i+1];
            w_dn_pred[i] = r_preds[i+1];
        end
        w_dn_id[DEPTH-1]   = r_ids[DEPTH-1];
        w_dn_pred[DEPTH-1] = r_preds[DEPTH-1];
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_ids[i]   = r_ids[i];
            n_preds[i] = r_preds[i];
            if (i_push && !w_keep[i]) begin
                if (w_keep_up[i]) begin
                    n_ids[i]   = i_id;
                    n_preds[i] = i_pred;
                end else begin
                    n_ids[i]   = w_up_id[i];
                    n_preds[i] = w_up_pred[i];
                end
            end else if (i_pop) begin
                n_ids[i]   = w_dn_id[i];
                n_preds[i] = w_dn_pred[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids   <= n_ids;
        r_preds <= n_preds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head_id   = r_ids[0];
    assign o_head_pred = r_preds[0];
    assign o_count     = r_count;

endmodule

FILE: sv/psjf_datapath.sv
// Datapath: input capture, burst predictor, running thread state, queue and result registers.
module psjf_datapath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ID_BITS       = 8,
    parameter int FRACTION_BITS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psjf_pkg::t_cmd                      i_cmd,
    input  logic                                i_mode,
    input  logic [psjf_pkg::ID_IN_W-1:0]        i_thread_id,
    input  logic [psjf_pkg::BURST_W-1:0]        i_burst_ticks,
    output logic [psjf_pkg::ID_OUT_W-1:0]       o_running_now,
    output logic                                o_preempted,
    output logic [psjf_pkg::ID_OUT_W-1:0]       o_preempted_thread,
    output logic                                o_picked_valid,
    output logic [psjf_pkg::ID_OUT_W-1:0]       o_picked_thread,
    output logic [psjf_pkg::PRED_OUT_W-1:0]     o_picked_prediction,
    output logic                                o_queue_full,
    output logic [psjf_pkg::COUNT_OUT_W-1:0]    o_queue_count
);

    localparam int PRED_W = psjf_pkg::BURST_W + FRACTION_BITS;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic                           r_mode;
    logic [ID_BITS-1:0]             r_id;
    logic [psjf_pkg::BURST_W-1:0]   r_burst;
    logic [PRED_W-1:0]              r_pred;
    logic [PRED_W-1:0]              r_again;
    logic                           r_preempt;
    logic [PRED_W-1:0]              r_prev;
    logic [ID_BITS-1:0]             r_run_id;
    logic [PRED_W-1:0]              r_run_pred;

    logic [PRED_W:0]                w_sum;
    logic [PRED_W-1:0]              w_predict;
    logic                           w_run_zero;
    logic                           w_preempt;
    logic                           w_is_pick;
    logic                           w_full;
    logic                           w_empty;
    logic                           w_push;
    logic                           w_pop;
    logic                           w_picked;
    logic [ID_BITS-1:0]             w_push_id;
    logic [PRED_W-1:0]              w_push_pred;
    logic [ID_BITS-1:0]             w_head_id;
    logic [PRED_W-1:0]              w_head_pred;
    logic [CNT_W-1:0]               w_count;
    logic [CNT_W-1:0]               w_count_next;
    logic [ID_BITS-1:0]             w_next_run_id;
    logic [PRED_W-1:0]              w_next_run_pred;

    assign w_sum      = {1'b0, PRED_W'(r_burst) << FRACTION_BITS} + {1'b0, r_prev};
    assign w_predict  = w_sum[PRED_W:1];
    assign w_run_zero = (r_run_id == '0);
    assign w_preempt  = !w_run_zero && (r_run_id != r_id) &&
        psjf_pkg::key_less(psjf_pkg::KEY_PRED_W'(r_pred), psjf_pkg::KEY_ID_W'(r_id),
                           psjf_pkg::KEY_PRED_W'(r_run_pred),
                           psjf_pkg::KEY_ID_W'(r_run_id));

    assign w_is_pick   = (r_mode == psjf_pkg::MODE_PICK);
    assign w_full      = (w_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (w_count == '0);
    assign w_picked    = w_is_pick && !w_empty;
    assign w_push      = i_cmd.commit && !w_is_pick && !w_full;
    assign w_pop       = i_cmd.commit && w_picked;
    assign w_push_id   = r_preempt ? r_run_id : r_id;
    assign w_push_pred = r_preempt ? r_again : r_pred;

    psjf_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .ID_W   (ID_BITS),
        .PRED_W (PRED_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop       (w_pop),
        .i_id        (w_push_id),
        .i_pred      (w_push_pred),
        .o_head_id   (w_head_id),
        .o_head_pred (w_head_pred),
        .o_count     (w_count)
    );

    always_comb begin
        w_next_run_id   = r_run_id;
        w_next_run_pred = r_run_pred;
        w_count_next    = w_count;
        if (w_is_pick) begin
            if (!w_empty) begin
                w_next_run_id   = w_head_id;
                w_next_run_pred = w_head_pred;
                w_count_next    = w_count - CNT_W'(1);
            end
        end else begin
            if (r_preempt) begin
                w_next_run_id   = r_id;
                w_next_run_pred = r_pred;
            end
            if (!w_full) begin
                w_count_next = w_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_id    <= ID_BITS'(i_thread_id);
            r_burst <= i_burst_ticks;
        end
        if (i_cmd.predict) begin
            r_pred <= w_run_zero ? '0 : w_predict;
        end
        if (i_cmd.repredict) begin
            r_preempt <= w_preempt;
            r_again   <= w_predict;
        end
        if (i_cmd.commit) begin
            o_running_now       <= psjf_pkg::ID_OUT_W'(32'(w_next_run_id));
            o_preempted         <= !w_is_pick && r_preempt;
            o_preempted_thread  <= (!w_is_pick && r_preempt)
                                   ? psjf_pkg::ID_OUT_W'(32'(r_run_id)) : '0;
            o_picked_valid      <= w_picked;
            o_picked_thread     <= w_picked ? psjf_pkg::ID_OUT_W'(32'(w_head_id)) : '0;
            o_picked_prediction <= w_picked ? psjf_pkg::PRED_OUT_W'(32'(w_head_pred)) : '0;
            o_queue_full        <= !w_is_pick && w_full;
            o_queue_count       <= psjf_pkg::COUNT_OUT_W'(32'(w_count_next));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_run_id   <= '0;
            r_run_pred <= '0;
        end else begin
            if (i_cmd.predict && !w_run_zero) begin
                r_prev <= w_predict;
            end
            if (i_cmd.repredict && w_preempt) begin
                r_prev <= w_predict;
            end
            if (i_cmd.commit) begin
                r_run_id   <= w_next_run_id;
                r_run_pred <= w_next_run_pred;
            end
        end
    end

endmodule

FILE: sv/psjf_ctrl.sv
// Controller state machine that sequences capture, prediction, commit and result hand-off.
module psjf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_mode,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output psjf_pkg::t_cmd  o_cmd
);

    psjf_pkg::t_state r_state;
    psjf_pkg::t_state n_state;
    logic             r_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psjf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_mode == psjf_pkg::MODE_PICK) ? psjf_pkg::S_COMMIT
                                                              : psjf_pkg::S_PREDICT;
                end
            end
            psjf_pkg::S_PREDICT: begin
                n_state = psjf_pkg::S_REPREDICT;
            end
            psjf_pkg::S_REPREDICT: begin
                n_state = psjf_pkg::S_COMMIT;
            end
            psjf_pkg::S_COMMIT: begin
                if (w_slot_free) begin
                    n_state = psjf_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == psjf_pkg::S_IDLE);
        o_cmd.capture   = (r_state == psjf_pkg::S_IDLE) && i_in_valid;
        o_cmd.predict   = (r_state == psjf_pkg::S_PREDICT);
        o_cmd.repredict = (r_state == psjf_pkg::S_REPREDICT);
        o_cmd.commit    = (r_state == psjf_pkg::S_COMMIT) && w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psjf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/preemptive_sjf_ready_queue.sv
// Top level of the preemptive shortest-job-first ready queue.
//
//   Channel   Handshake                   Payload
//   input     i_in_valid / o_in_ready     i_mode, i_thread_id, i_burst_ticks
//   output    o_out_valid / i_out_ready   o_running_now ... o_queue_count
//
// A pick transfer goes from acceptance straight to the commit state, where the queue shifts; a ready
// transfer first passes the predict and repredict states, two passes through the shared prediction adder.
// The block accepts one item at a time and is ready again the cycle after the commit.
// A result waiting in the output register holds the next item in its commit cycle.
// Reset is synchronous; the queue starts empty with the init thread running.
module preemptive_sjf_ready_queue #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ID_BITS       = 8,
    parameter int FRACTION_BITS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [psjf_pkg::ID_IN_W-1:0]        i_thread_id,
    input  logic [psjf_pkg::BURST_W-1:0]        i_burst_ticks,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [psjf_pkg::ID_OUT_W-1:0]       o_running_now,
    output logic                                o_preempted,
    output logic [psjf_pkg::ID_OUT_W-1:0]       o_preempted_thread,
    output logic                                o_picked_valid,
    output logic [psjf_pkg::ID_OUT_W-1:0]       o_picked_thread,
    output logic [psjf_pkg::PRED_OUT_W-1:0]     o_picked_prediction,
    output logic                                o_queue_full,
    output logic [psjf_pkg::COUNT_OUT_W-1:0]    o_queue_count
);

    psjf_pkg::t_cmd w_cmd;

    psjf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    psjf_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ID_BITS       (ID_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_mode              (i_mode),
        .i_thread_id         (i_thread_id),
        .i_burst_ticks       (i_burst_ticks),
        .o_running_now       (o_running_now),
        .o_preempted         (o_preempted),
        .o_preempted_thread  (o_preempted_thread),
        .o_picked_valid      (o_picked_valid),
        .o_picked_thread     (o_picked_thread),
        .o_picked_prediction (o_picked_prediction),
        .o_queue_full        (o_queue_full),
        .o_queue_count       (o_queue_count)
    );

endmodule

FILE: sv/psjf_checker.sv
// Port-level checker for the ready queue, bound to the top level.
`include "preemptive_sjf_ready_queue_defines.svh"

module psjf_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [psjf_pkg::ID_OUT_W-1:0]       o_running_now,
    input  logic                                o_preempted,
    input  logic [psjf_pkg::ID_OUT_W-1:0]       o_preempted_thread,
    input  logic                                o_picked_valid,
    input  logic [psjf_pkg::ID_OUT_W-1:0]       o_picked_thread,
    input  logic [psjf_pkg::PRED_OUT_W-1:0]     o_picked_prediction,
    input  logic                                o_queue_full,
    input  logic [psjf_pkg::COUNT_OUT_W-1:0]    o_queue_count
);

    `PSJF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_running_now) && $stable(o_picked_prediction) && $stable(o_queue_count), "stalled result changed")

    `PSJF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "accepted a second item while busy")

    `PSJF_ASSERT_NOW(a_pick_runs, o_out_valid && o_picked_valid, (o_running_now == o_picked_thread) && !o_preempted && !o_queue_full, "picked thread is not running")

    `PSJF_ASSERT_NOW(a_preempt_ids, o_out_valid && o_preempted, (o_preempted_thread != '0) && (o_running_now != o_preempted_thread), "preemption of init or same thread")

endmodule

bind preemptive_sjf_ready_queue psjf_checker u_psjf_checker (.*);
